[hw/rtl/vtgd_pkg.sv]
// Shared types, codes and constants of the vector tile geometry decoder.
package vtgd_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam int PAYLOAD_W = 162;
	localparam int TDATA_W = ((PAYLOAD_W + 7) / 8) * 8;
	localparam int PAD_W = TDATA_W - PAYLOAD_W;

	localparam logic [2:0] CMD_MOVE = 3'd1;
	localparam logic [2:0] CMD_LINE = 3'd2;
	localparam logic [2:0] CMD_CLOSE = 3'd7;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_RING = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	localparam logic [1:0] ST_NORMAL = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	localparam logic [31:0] RING_MIN = 32'd3;

	typedef enum logic [1:0] {
		PH_CMD,
		PH_DX,
		PH_DY
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CLOSE_MUL,
		BK_CLOSE_OUT,
		BK_POINT,
		BK_AREA_MUL,
		BK_AREA_ACC,
		BK_FINISH
	} bk_state_t;

	// steps an op asks of the back end, carried out in this order
	typedef struct packed {
		logic close_a;
		logic point;
		logic close_b;
		logic finish;
	} steps_t;

	typedef struct packed {
		steps_t      steps;
		logic [1:0]  status;
		logic [31:0] dx;
		logic [31:0] dy;
	} op_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage

[hw/rtl/vtgd_front.sv]
// Front end: parses geometry words into back-end ops.
module vtgd_front import vtgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // word
	input  logic        s_axis_tlast,   // last_word
	input  q_stat_t     q_stat,
	output logic        push,
	output op_t         op
);

	phase_t      phase_q, phase_d;
	logic        is_move_q, is_move_d;
	logic [28:0] left_q, left_d;
	logic [28:0] left_dec;
	logic [28:0] cnt;
	logic [2:0]  id;
	logic        halted_q, halted_d;
	logic [31:0] pdx_q, pdx_d;
	logic        accept;
	logic        clear;

	function automatic logic [31:0] unzig(input logic [31:0] v);
		return {1'b0, v[31:1]} ^ {32{v[0]}};
	endfunction

	assign s_axis_tready = !q_stat.full;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign cnt = s_axis_tdata[31:3];
	assign id = s_axis_tdata[2:0];
	assign left_dec = (left_q != '0) ? left_q - 29'd1 : '0;

	always_comb begin
		phase_d = phase_q;
		is_move_d = is_move_q;
		left_d = left_q;
		halted_d = halted_q;
		pdx_d = pdx_q;
		push = 1'b0;
		clear = 1'b0;
		op = '0;
		op.dx = unzig(pdx_q);
		op.dy = unzig(s_axis_tdata);
		if (accept) begin
			if (halted_q) begin
				clear = s_axis_tlast;
			end else if (phase_q == PH_DX && !s_axis_tlast) begin
				pdx_d = s_axis_tdata;
				phase_d = PH_DY;
			end else if (phase_q == PH_DY) begin
				push = 1'b1;
				op.steps.close_a = is_move_q;
				op.steps.point = 1'b1;
				op.steps.close_b = s_axis_tlast;
				op.steps.finish = s_axis_tlast;
				left_d = left_dec;
				phase_d = (left_dec == '0) ? PH_CMD : PH_DX;
				clear = s_axis_tlast;
			end else begin
				priority if (cnt == '0) begin
					push = 1'b1;
					op.steps.finish = 1'b1;
					op.status = ST_ZERO;
					halted_d = 1'b1;
					phase_d = PH_CMD;
				end else if (id == CMD_MOVE || id == CMD_LINE) begin
					is_move_d = (id == CMD_MOVE);
					left_d = cnt;
					phase_d = PH_DX;
					push = s_axis_tlast;
					op.steps.close_b = s_axis_tlast;
					op.steps.finish = s_axis_tlast;
				end else if (id == CMD_CLOSE) begin
					phase_d = PH_CMD;
					push = 1'b1;
					op.steps.close_b = 1'b1;
					op.steps.finish = s_axis_tlast;
				end else begin
					push = 1'b1;
					op.steps.finish = 1'b1;
					op.status = ST_UNKNOWN;
					halted_d = 1'b1;
					phase_d = PH_CMD;
				end
				clear = s_axis_tlast;
			end
			if (clear) begin
				phase_d = PH_CMD;
				is_move_d = 1'b0;
				left_d = '0;
				halted_d = 1'b0;
				pdx_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			is_move_q <= 1'b0;
			left_q <= '0;
			halted_q <= 1'b0;
			pdx_q <= '0;
		end else begin
			phase_q <= phase_d;
			is_move_q <= is_move_d;
			left_q <= left_d;
			halted_q <= halted_d;
			pdx_q <= pdx_d;
		end
	end

endmodule

[hw/rtl/vtgd_queue.sv]
// Short op queue between front and back end.
module vtgd_queue import vtgd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  op_t     push_op,
	input  logic    pop,
	output op_t     head,
	output q_stat_t q_stat
);

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head = mem_q[rd_ptr_q];
	assign q_stat.valid = (cnt_q != '0);
	assign q_stat.full = (cnt_q == QCNT_W'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + QCNT_W'(1);
				2'b01: cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule

[hw/rtl/vtgd_back.sv]
// Back end: cursor, ring area and result sequencing.
module vtgd_back import vtgd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  op_t                  head,
	input  q_stat_t              q_stat,
	output logic                 pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [TDATA_W-1:0]   m_axis_tdata,  // point_x, point_y, twice_area, ring_size, end_status
	output logic [1:0]           m_axis_tuser,  // kind
	output logic                 m_axis_tlast   // final_of_run
);

	bk_state_t state_q, state_d;
	steps_t    pend_q, pend_d, src;
	logic [1:0]  status_q;
	logic [31:0] dx_q, dy_q;

	logic [31:0] cur_x_q, cur_y_q, first_x_q, first_y_q, old_x_q, old_y_q;
	logic [63:0] area_q;
	logic [31:0] ring_q;
	logic [31:0] nx, ny;
	logic signed [31:0] ma, mb, mc, md;
	logic signed [63:0] prod_p_q, prod_q_q;

	logic out_free;
	logic emit_point, emit_close, emit_finish, do_mul, do_acc, load;
	logic out_valid_q, out_final_q;
	logic [1:0]  out_kind_q, out_status_q;
	logic [31:0] out_x_q, out_y_q, out_size_q;
	logic [63:0] out_area_q;

	assign out_free = !out_valid_q || m_axis_tready;
	assign nx = cur_x_q + dx_q;
	assign ny = cur_y_q + dy_q;
	assign load = pop;

	always_comb begin
		state_d = state_q;
		pend_d = pend_q;
		src = '0;
		pop = 1'b0;
		emit_point = 1'b0;
		emit_close = 1'b0;
		emit_finish = 1'b0;
		do_mul = 1'b0;
		do_acc = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (pend_q != '0) begin
					src = pend_q;
				end else if (q_stat.valid) begin
					src = head.steps;
					pop = 1'b1;
				end
				pend_d = src;
				priority if (src.close_a) begin
					pend_d.close_a = 1'b0;
					if (ring_q >= RING_MIN) begin
						state_d = BK_CLOSE_MUL;
					end
				end else if (src.point) begin
					state_d = BK_POINT;
				end else if (src.close_b) begin
					pend_d.close_b = 1'b0;
					if (ring_q >= RING_MIN) begin
						state_d = BK_CLOSE_MUL;
					end
				end else if (src.finish) begin
					state_d = BK_FINISH;
				end else begin
					state_d = BK_IDLE;
				end
			end
			BK_CLOSE_MUL: begin
				do_mul = 1'b1;
				state_d = BK_CLOSE_OUT;
			end
			BK_CLOSE_OUT: begin
				if (out_free) begin
					emit_close = 1'b1;
					state_d = BK_IDLE;
				end
			end
			BK_POINT: begin
				if (out_free) begin
					emit_point = 1'b1;
					pend_d.point = 1'b0;
					state_d = (ring_q == '0) ? BK_IDLE : BK_AREA_MUL;
				end
			end
			BK_AREA_MUL: begin
				do_mul = 1'b1;
				state_d = BK_AREA_ACC;
			end
			BK_AREA_ACC: begin
				do_acc = 1'b1;
				state_d = BK_IDLE;
			end
			BK_FINISH: begin
				if (out_free) begin
					emit_finish = 1'b1;
					pend_d.finish = 1'b0;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// shared multiplier pair: closing edge or newly added edge
	always_comb begin
		if (state_q == BK_CLOSE_MUL) begin
			ma = cur_x_q;
			mb = first_y_q;
			mc = first_x_q;
			md = cur_y_q;
		end else begin
			ma = old_x_q;
			mb = cur_y_q;
			mc = cur_x_q;
			md = old_y_q;
		end
	end

	always_ff @(posedge clk) begin
		if (do_mul) begin
			prod_p_q <= 64'(ma) * 64'(mb);
			prod_q_q <= 64'(mc) * 64'(md);
		end
		if (load) begin
			status_q <= head.status;
			dx_q <= head.dx;
			dy_q <= head.dy;
		end
		if (emit_point) begin
			old_x_q <= cur_x_q;
			old_y_q <= cur_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			pend_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			area_q <= '0;
			ring_q <= '0;
		end else begin
			state_q <= state_d;
			pend_q <= pend_d;
			if (emit_point) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				if (ring_q == '0) begin
					first_x_q <= nx;
					first_y_q <= ny;
				end
				if (ring_q != '1) begin
					ring_q <= ring_q + 32'd1;
				end
			end
			if (do_acc) begin
				area_q <= area_q + 64'(prod_p_q) - 64'(prod_q_q);
			end
			if (emit_close) begin
				area_q <= '0;
				ring_q <= '0;
			end
			if (emit_finish) begin
				cur_x_q <= '0;
				cur_y_q <= '0;
				first_x_q <= '0;
				first_y_q <= '0;
				area_q <= '0;
				ring_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_point || emit_close || emit_finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_point || emit_close || emit_finish) begin
			out_x_q <= '0;
			out_y_q <= '0;
			out_area_q <= '0;
			out_size_q <= '0;
			out_status_q <= ST_NORMAL;
			if (emit_point) begin
				out_kind_q <= KIND_POINT;
				out_x_q <= nx;
				out_y_q <= ny;
				out_final_q <= !pend_q.finish;
			end else if (emit_close) begin
				out_kind_q <= KIND_RING;
				out_area_q <= area_q + 64'(prod_p_q) - 64'(prod_q_q);
				out_size_q <= ring_q;
				out_final_q <= !pend_q.point && !pend_q.finish;
			end else begin
				out_kind_q <= KIND_FINISH;
				out_status_q <= status_q;
				out_final_q <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_kind_q;
	assign m_axis_tlast = out_final_q;
	assign m_axis_tdata = {{PAD_W{1'b0}}, out_status_q, out_size_q, out_area_q,
		out_y_q, out_x_q};

	a_close_big: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CLOSE_OUT) |-> (ring_q >= RING_MIN))
		else $error("ring closed with fewer than three points");
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_finish |=> (ring_q == '0 && area_q == '0 && pend_q.finish == 1'b0))
		else $error("feature finish left ring state behind");

endmodule

[hw/rtl/vector_tile_geometry_decoder_core.sv]
// Top level of the vector tile geometry decoder.
// Decodes one feature's geometry words (commands and zigzag deltas, tlast on the final
// word) into a stream of point, ring-close and feature-finish items. The front end takes
// one word per cycle and only stalls when its four-entry op queue is full; non-final delta x
// words and non-final MoveTo/LineTo words cost it nothing downstream. The back end chooses
// each step of an op in its idle state (a skipped close of a short ring included), then runs
// a point through BK_POINT (and BK_AREA_MUL and BK_AREA_ACC when it is not the first of its
// ring, for the edge product pair and the area add), a ring close through BK_CLOSE_MUL and
// BK_CLOSE_OUT and a feature finish through BK_FINISH, each result step waiting while the
// output register is full. The single shared multiplier pair and the output register set
// its pace; it pops the next op only once every step of the current op is done.
module vector_tile_geometry_decoder_core import vtgd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [31:0]        s_axis_tdata,   // word
	input  logic               s_axis_tlast,   // last_word
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // point_x, point_y, twice_area, ring_size, end_status
	output logic [1:0]         m_axis_tuser,   // kind
	output logic               m_axis_tlast    // final_of_run
);

	logic    push;
	logic    pop;
	op_t     push_op;
	op_t     head;
	q_stat_t q_stat;

	vtgd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.q_stat       (q_stat),
		.push         (push),
		.op           (push_op)
	);

	vtgd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	vtgd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

[dv/vector_tile_geometry_decoder_core_tb.sv]
// Self-checking bench: directed and random geometry word streams against an in-bench decoder model.
module vector_tile_geometry_decoder_core_tb import vtgd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 32;
	localparam int RANDOM_WORDS = 200;
	localparam int PACE_LEN = 50;

	typedef struct {
		logic [31:0] word;
		logic        last;
	} geo_word_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [63:0] area;
		logic [31:0] size;
		logic [1:0]  status;
		logic        fin;
	} geo_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_valid = 1'b0;
	logic               s_ready;
	logic [31:0]        s_data = '0;
	logic               s_last = 1'b0;
	logic               m_valid;
	logic               m_ready = 1'b0;
	logic [TDATA_W-1:0] m_data;
	logic [1:0]         m_user;
	logic               m_last;

	geo_word_t   words_q[$];
	logic [31:0] feat_q[$];
	geo_result_t run_q[$];
	geo_result_t results_due[$];
	geo_result_t due;

	int n_sent = 0;
	int errors = 0;
	int quiet_cycles = 0;
	int n_queued;
	int send_pct;
	int recv_pct;

	// decoder model state
	phase_t      ph;
	logic [2:0]  cmd_act;
	logic [31:0] left, pdx, cx, cy, fx, fy, rc;
	logic [63:0] asum;
	logic [1:0]  halt;

	vector_tile_geometry_decoder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tlast  (s_last),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user),
		.m_axis_tlast  (m_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// pacing: none, sender idle, receiver stall, both
	always_comb begin
		case ((n_sent / PACE_LEN) % 4)
			1: begin
				send_pct = 58;
				recv_pct = 0;
			end
			2: begin
				send_pct = 0;
				recv_pct = 58;
			end
			3: begin
				send_pct = 13;
				recv_pct = 13;
			end
			default: begin
				send_pct = 0;
				recv_pct = 0;
			end
		endcase
	end

	function automatic bit pause(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [31:0] unzig(input logic [31:0] v);
		return (v >> 1) ^ {32{v[0]}};
	endfunction

	function automatic logic [31:0] zz(input logic [31:0] v);
		return (v << 1) ^ {32{v[31]}};
	endfunction

	function automatic logic [31:0] cmd(input logic [2:0] id, input logic [28:0] count);
		return {count, id};
	endfunction

	function automatic logic [63:0] edge_cross(input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] bx, input logic [31:0] by);
		longint p;
		longint q;
		p = longint'($signed(ax)) * longint'($signed(by));
		q = longint'($signed(bx)) * longint'($signed(ay));
		return 64'(p) - 64'(q);
	endfunction

	task automatic clear_feature();
		ph = PH_CMD;
		cmd_act = '0;
		left = '0;
		pdx = '0;
		cx = '0;
		cy = '0;
		fx = '0;
		fy = '0;
		asum = '0;
		rc = '0;
		halt = '0;
	endtask

	task automatic emit(input logic [1:0] kind, input logic [31:0] x, input logic [31:0] y,
			input logic [63:0] area, input logic [31:0] size, input logic [1:0] status);
		geo_result_t r;
		r.kind = kind;
		r.x = x;
		r.y = y;
		r.area = area;
		r.size = size;
		r.status = status;
		r.fin = 1'b0;
		run_q.insert(run_q.size(), r);
	endtask

	// cursor is always the last point of the ring here
	task automatic close_ring();
		if (rc >= RING_MIN) begin
			emit(KIND_RING, '0, '0, asum + edge_cross(cx, cy, fx, fy), rc, ST_NORMAL);
			asum = '0;
			rc = '0;
		end
	endtask

	task automatic finish_normal();
		close_ring();
		emit(KIND_FINISH, '0, '0, '0, '0, ST_NORMAL);
		clear_feature();
	endtask

	task automatic stop(input logic [1:0] status, input logic last);
		emit(KIND_FINISH, '0, '0, '0, '0, status);
		if (last) begin
			clear_feature();
		end else begin
			halt = status;
			ph = PH_CMD;
		end
	endtask

	task automatic decode_word(input logic [31:0] w, input logic last);
		logic [31:0] nx;
		logic [31:0] ny;
		logic [31:0] cnt;
		logic [2:0]  id;
		run_q.delete();
		if (halt != '0) begin
			if (last)
				clear_feature();
			return;
		end
		if (ph == PH_DX && !last) begin
			pdx = w;
			ph = PH_DY;
			return;
		end
		if (ph == PH_DY) begin
			nx = cx + unzig(pdx);
			ny = cy + unzig(w);
			if (cmd_act == CMD_MOVE)
				close_ring();
			if (rc == '0) begin
				fx = nx;
				fy = ny;
			end else begin
				asum = asum + edge_cross(cx, cy, nx, ny);
			end
			if (rc != '1)
				rc = rc + 1;
			cx = nx;
			cy = ny;
			emit(KIND_POINT, nx, ny, '0, '0, ST_NORMAL);
			if (left != '0)
				left = left - 1;
			ph = (left == '0) ? PH_CMD : PH_DX;
			if (last)
				finish_normal();
		end else begin
			id = w[2:0];
			cnt = w >> 3;
			if (cnt == '0) begin
				stop(ST_ZERO, last);
			end else if (id == CMD_MOVE || id == CMD_LINE) begin
				cmd_act = id;
				left = cnt;
				ph = PH_DX;
				if (last)
					finish_normal();
			end else if (id == CMD_CLOSE) begin
				ph = PH_CMD;
				close_ring();
				if (last)
					finish_normal();
			end else begin
				stop(ST_UNKNOWN, last);
			end
		end
		if (run_q.size() > 0)
			run_q[run_q.size() - 1].fin = 1'b1;
		foreach (run_q[i])
			results_due.insert(results_due.size(), run_q[i]);
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// feature words collected in feat_q, last flag on the final one
	task automatic flush_feature();
		geo_word_t it;
		foreach (feat_q[i]) begin
			it.word = feat_q[i];
			it.last = (i == feat_q.size() - 1);
			words_q.insert(words_q.size(), it);
		end
		n_queued += feat_q.size();
		feat_q.delete();
	endtask

	function automatic logic [31:0] rnd_delta();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70)
			return zz(32'($urandom_range(400)) - 32'd200);
		else if (sel < 90)
			return zz({{16{1'b0}}, 16'($urandom)} - 32'h8000);
		else
			return $urandom;
	endfunction

	task automatic build_feature();
		int nrings;
		int k;
		nrings = $urandom_range(1, 3);
		for (int r = 0; r < nrings; r++) begin
			k = ($urandom_range(9) == 0) ? 2 : 1;
			feat_q.insert(feat_q.size(), cmd(CMD_MOVE, 29'(k)));
			repeat (2 * k)
				feat_q.insert(feat_q.size(), rnd_delta());
			k = $urandom_range(1, 5);
			feat_q.insert(feat_q.size(), cmd(CMD_LINE, 29'(k)));
			repeat (2 * k)
				feat_q.insert(feat_q.size(), rnd_delta());
			if ($urandom_range(4) != 0)
				feat_q.insert(feat_q.size(), cmd(CMD_CLOSE, 29'($urandom_range(1, 2))));
		end
	endtask

	task automatic add_random_feature();
		int sel;
		int pos;
		logic [2:0] bad_id;
		build_feature();
		sel = $urandom_range(99);
		if (sel < 65) begin
			// well-formed as built
		end else if (sel < 80) begin
			pos = $urandom_range(1, feat_q.size());
			while (feat_q.size() > pos)
				void'(feat_q.pop_back());
		end else if (sel < 92) begin
			pos = $urandom_range(feat_q.size() - 1);
			if ($urandom_range(1)) begin
				feat_q.insert(pos, cmd(3'($urandom), '0));
			end else begin
				bad_id = 3'($urandom_range(3, 6));
				if ($urandom_range(3) == 0)
					bad_id = 3'd0;
				feat_q.insert(pos, cmd(bad_id, 29'($urandom)));
			end
		end else begin
			feat_q.delete();
			repeat ($urandom_range(1, 6))
				feat_q.insert(feat_q.size(), $urandom);
		end
		flush_feature();
	endtask

	task automatic add_directed();
		// triangle, then an extreme point followed by a final ClosePath
		feat_q = '{cmd(CMD_MOVE, 29'd1), zz(0), zz(0), cmd(CMD_LINE, 29'd2), zz(10), zz(0),
			zz(0), zz(10), cmd(CMD_CLOSE, 29'd1), cmd(CMD_MOVE, 29'd1), 32'hFFFF_FFFF,
			32'hFFFF_FFFE, cmd(CMD_CLOSE, 29'd1)};
		flush_feature();
		// zero count stop, words ignored until the final one
		feat_q = '{cmd(CMD_MOVE, 29'd0), 32'hFFFF_FFFF, 32'h1234_5678};
		flush_feature();
		// unknown id with maximum count as the last word
		feat_q = '{cmd(3'd3, '1)};
		flush_feature();
		// maximum count, one point, then a lone trailing delta
		feat_q = '{cmd(CMD_LINE, '1), zz(3), zz(4), zz(1)};
		flush_feature();
		// MoveTo as the last word
		feat_q = '{cmd(CMD_MOVE, 29'd1)};
		flush_feature();
		// full-width delta pair as the last word of a point
		feat_q = '{cmd(CMD_LINE, 29'd1), 32'h8000_0001, 32'h7FFF_FFFF};
		flush_feature();
	endtask

	always @(posedge clk or negedge arst_n) begin
		geo_word_t it;
		if (!arst_n) begin
			s_valid <= 1'b0;
			s_data <= '0;
			s_last <= 1'b0;
			n_sent <= 0;
		end else begin
			if (s_valid && s_ready) begin
				decode_word(s_data, s_last);
				n_sent <= n_sent + 1;
			end
			if (!s_valid || s_ready) begin
				if (words_q.size() > 0 && !pause(send_pct)) begin
					it = words_q.pop_front();
					s_valid <= 1'b1;
					s_data <= it.word;
					s_last <= it.last;
				end else begin
					s_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready <= 1'b0;
		end else begin
			if (m_valid && m_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected item, kind %0d, data %h, last %b",
						$time, m_user, m_data, m_last);
					errors++;
				end else begin
					due = results_due.pop_front();
					check_field("kind", 64'(due.kind), 64'(m_user));
					check_field("point_x", 64'(due.x), 64'(m_data[31:0]));
					check_field("point_y", 64'(due.y), 64'(m_data[63:32]));
					check_field("twice_area", due.area, m_data[127:64]);
					check_field("ring_size", 64'(due.size), 64'(m_data[159:128]));
					check_field("end_status", 64'(due.status), 64'(m_data[161:160]));
					check_field("final_of_run", 64'(due.fin), 64'(m_last));
				end
			end
			m_ready <= !pause(recv_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_valid && s_ready) || (m_valid && m_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		clear_feature();
		n_queued = 0;
		add_directed();
		while (n_queued < RANDOM_WORDS)
			add_random_feature();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (words_q.size() != 0 || s_valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
